FILE: hw/rtl/sh3_pkg.sv
// Shared types, constants and helper functions of the 3x3 RGB sharpen filter.
// Depends on nothing; the top level, sh3_ctrl and sh3_sharpen import it.
`timescale 1ns / 1ps

package sh3_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;

   localparam int CFG_W     = 11;                          // register data width
   localparam int CSR_IDX_W = 1;                           // register index width
   localparam int CH_W      = 8;                           // one color component
   localparam int PIX_W     = 3 * CH_W;                    // packed red, green, blue
   localparam int LINE_W    = 2 * PIX_W;                   // {above, current} entry
   localparam int COL_W     = $clog2(MAX_WIDTH);           // column index
   localparam int WID_W     = $clog2(MAX_WIDTH + 1);       // width value 1..MAX_WIDTH
   localparam int HGT_W     = $clog2(MAX_HEIGHT + 1);      // height value, output row
   localparam int ROW_W     = $clog2(MAX_HEIGHT + 2);      // input row incl. flush rows

   localparam int KERNEL_CENTER = 9;
   localparam int CH_MAX        = 255;
   localparam int POS_W         = 12;                      // 9 * 255
   localparam int NEG_W         = 11;                      // 8 * 255
   localparam int DIFF_W        = 13;                      // signed difference

   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

   localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd640;
   localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd480;

   typedef logic [PIX_W-1:0] pix_type;
   typedef pix_type [2:0]    col_type;   // [0] top, [1] middle, [2] bottom
   typedef col_type [2:0]    win_type;   // [0] left, [1] center, [2] right

   // Per-item decisions taken where the item enters, used one stage later.
   typedef struct packed {
      logic have;        // a line entry feeds the window (rows 1..height)
      logic top_above;   // top row comes from the row above (row 2 and later)
      logic bot_pixel;   // bottom row is the incoming pixel (pixel rows)
      logic wr_line;     // the pixel is stored in the line memory
      logic col0;        // first column of a row
      logic edge_emit;   // first column, row 2 on: emit right-edge result
   } ctl_type;

   function automatic logic [WID_W-1:0] clamp_width(input logic [CFG_W-1:0] v);
      if (v == '0) begin
         return WID_W'(1);
      end
      if (int'(v) > MAX_WIDTH) begin
         return WID_W'(MAX_WIDTH);
      end
      return WID_W'(v);
   endfunction

   function automatic logic [HGT_W-1:0] clamp_height(input logic [CFG_W-1:0] v);
      if (v == '0) begin
         return HGT_W'(1);
      end
      if (int'(v) > MAX_HEIGHT) begin
         return HGT_W'(MAX_HEIGHT);
      end
      return HGT_W'(v);
   endfunction

endpackage

FILE: hw/rtl/sharpen_3x3_rgb.sv
// Top level of the streaming 3x3 RGB sharpen filter.
// Depends on sh3_pkg, sh3_ram, sh3_ctrl and sh3_sharpen.
//
// Usage: pixels of a frame enter in raster order on the req_ channel, one item
// per accepted handshake (req_valid high, req_stall low). After the last pixel
// of a frame, image_width+1 flush items (req_flush_slot high) push out the
// remaining results; then the next frame starts. A flush item that arrives while
// pixels are still expected is taken and dropped.
// Each result pixel belongs to the input pixel one row plus one column earlier,
// and rsp_end_of_frame marks the last result of a frame. The block takes one
// item per clock while req_stall is low. An accepted item is registered in the
// window stage, where the line memory read issued at acceptance returns, and
// its result is registered for rsp_ when the window stage moves on.
// One dual-ported line memory (one write, one registered read per cycle) holds
// the current and previous row of each column and sets the two-stage depth.
// When rsp_stall holds a result, req_stall rises in the same cycle only if the
// window stage is also full; the block otherwise keeps taking items.
// Register writes on csr_ are always ready, are meant for an idle block, and
// restart the frame. Reset loads a 640 by 480 frame size and clears the
// position counters; the line memory is not cleared, and the entries read in
// the first row before they are written give data that is never used.
`timescale 1ns / 1ps

module sharpen_3x3_rgb (
   input  logic                          clock,
   input  logic                          reset,
   // Pixel input channel.
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [7:0]                    req_in_red,
   input  logic [7:0]                    req_in_green,
   input  logic [7:0]                    req_in_blue,
   input  logic                          req_flush_slot,
   // Result channel.
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [7:0]                    rsp_out_red,
   output logic [7:0]                    rsp_out_green,
   output logic [7:0]                    rsp_out_blue,
   output logic                          rsp_end_of_frame,
   // Register write channel.
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [sh3_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [sh3_pkg::CFG_W-1:0]     csr_wdata
);
   import sh3_pkg::*;

   // Frame size registers and their clamped values.
   logic [CFG_W-1:0] width_ff;
   logic [CFG_W-1:0] height_ff;
   logic [WID_W-1:0] w_eff;
   logic [HGT_W-1:0] h_eff;
   logic             csr_write;

   // Input side.
   logic             accept;
   logic             keep;
   logic [COL_W-1:0] rd_addr;
   ctl_type          ctl;

   // Window stage: one item plus its line memory data.
   logic             s1_valid_ff, s1_valid_in;
   ctl_type          s1_ctl_ff;
   logic [COL_W-1:0] s1_col_ff;
   pix_type          s1_pix_ff;
   logic             s1_fwd_ff;
   logic [LINE_W-1:0] s1_fwd_data_ff;
   logic             s1_go;
   logic             s1_emit;

   // Line memory.
   logic              ram_we;
   logic              ram_re;
   logic [LINE_W-1:0] ram_wd;
   logic [LINE_W-1:0] ram_q;
   logic [LINE_W-1:0] line;
   logic              fwd_in;
   pix_type           cur;
   pix_type           abv;
   col_type           new_col;

   // 3x3 window and the kernel.
   win_type           win_ff, win_in;
   win_type           shifted;
   pix_type           sharp;

   // Output position and result register.
   logic [COL_W-1:0]  out_col_ff, out_col_in;
   logic [HGT_W-1:0]  out_row_ff, out_row_in;
   logic              eof;
   logic              out_free;
   logic              rsp_valid_ff;
   pix_type           rsp_pix_ff;
   logic              rsp_eof_ff;

   // ---------------------------------------------------------------------
   // Registers. Writes are taken at any time and restart the frame.
   // ---------------------------------------------------------------------
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_IMAGE_WIDTH: begin
               width_ff <= csr_wdata;
            end
            REG_IMAGE_HEIGHT: begin
               height_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   // A zero size acts as one, an oversized one as the maximum.
   assign w_eff = clamp_width(width_ff);
   assign h_eff = clamp_height(height_ff);

   // ---------------------------------------------------------------------
   // Flow control. The window stage moves on whenever the result register
   // is empty or being emptied, whether or not the item makes a result.
   // ---------------------------------------------------------------------
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_go     = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   sh3_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .restart (csr_write),
      .advance (accept),
      .flush   (req_flush_slot),
      .w_eff   (w_eff),
      .h_eff   (h_eff),
      .keep    (keep),
      .rd_addr (rd_addr),
      .ctl     (ctl)
   );

   // ---------------------------------------------------------------------
   // Line memory. Each entry holds the previous and current row of its
   // column. The read is issued when an item is accepted; the write comes
   // from the item leaving the window stage in that same cycle. Both hit the
   // same column only for a one-pixel-wide frame, and then the written value
   // is forwarded instead of the stale read.
   // ---------------------------------------------------------------------
   assign ram_re = accept && keep;
   assign ram_we = s1_go && s1_ctl_ff.wr_line;
   assign ram_wd = {cur, s1_pix_ff};
   assign fwd_in = ram_we && (s1_col_ff == rd_addr);

   sh3_ram #(
      .WIDTH (LINE_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (s1_col_ff),
      .wr_data (ram_wd),
      .rd_en   (ram_re),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   assign s1_valid_in = (accept && keep) ? 1'b1 : (s1_go ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && keep) begin
         s1_ctl_ff      <= ctl;
         s1_col_ff      <= rd_addr;
         s1_pix_ff      <= {req_in_red, req_in_green, req_in_blue};
         s1_fwd_ff      <= fwd_in;
         s1_fwd_data_ff <= ram_wd;
      end
   end

   // ---------------------------------------------------------------------
   // Window stage. Rows are clamped at the frame edges: the first row
   // stands in for the row above it, and in the flush row the middle row
   // stands in for the missing row below.
   // ---------------------------------------------------------------------
   assign line = s1_fwd_ff ? s1_fwd_data_ff : ram_q;
   assign cur  = line[PIX_W-1:0];
   assign abv  = line[LINE_W-1:PIX_W];

   always_comb begin
      new_col[0] = s1_ctl_ff.top_above ? abv : cur;
      new_col[1] = cur;
      new_col[2] = s1_ctl_ff.bot_pixel ? s1_pix_ff : cur;
   end

   // The first column of a row completes the previous row: its last result
   // is made with the right edge column repeated. Other columns shift in the
   // new column and emit the pixel one to the left of it.
   assign s1_emit = s1_ctl_ff.edge_emit || (!s1_ctl_ff.col0 && s1_ctl_ff.have);

   always_comb begin
      shifted[0] = win_ff[1];
      shifted[1] = win_ff[2];
      shifted[2] = s1_ctl_ff.edge_emit ? win_ff[2] : new_col;
   end

   always_comb begin
      win_in = win_ff;
      if (s1_go) begin
         if (s1_ctl_ff.col0 && s1_ctl_ff.have) begin
            // Start of a row: the left edge is repeated across the window.
            win_in[0] = new_col;
            win_in[1] = new_col;
            win_in[2] = new_col;
         end else if (s1_emit) begin
            win_in = shifted;
         end
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
   end

   sh3_sharpen u_sharpen (
      .win    (shifted),
      .result (sharp)
   );

   // ---------------------------------------------------------------------
   // Output position, end-of-frame flag and result register.
   // ---------------------------------------------------------------------
   assign eof = ((WID_W'(out_col_ff) + WID_W'(1)) == w_eff)
             && ((out_row_ff + HGT_W'(1)) == h_eff);

   always_comb begin
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (csr_write) begin
         out_col_in = '0;
         out_row_in = '0;
      end else if (s1_go && s1_emit) begin
         if (eof) begin
            out_col_in = '0;
            out_row_in = '0;
         end else if ((WID_W'(out_col_ff) + WID_W'(1)) == w_eff) begin
            out_col_in = '0;
            out_row_in = out_row_ff + HGT_W'(1);
         end else begin
            out_col_in = out_col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_col_ff   <= '0;
         out_row_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
         if (out_free) begin
            rsp_valid_ff <= s1_go && s1_emit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go && s1_emit) begin
         rsp_pix_ff <= sharp;
         rsp_eof_ff <= eof;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_red      = rsp_pix_ff[3*CH_W-1:2*CH_W];
   assign rsp_out_green    = rsp_pix_ff[2*CH_W-1:CH_W];
   assign rsp_out_blue     = rsp_pix_ff[CH_W-1:0];
   assign rsp_end_of_frame = rsp_eof_ff;

   // ---------------------------------------------------------------------
   // Assertions.
   // ---------------------------------------------------------------------

   // The input is held back only while a full window stage waits on a
   // stalled result.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall && s1_valid_ff))
      else $error("input stalled without a stalled result");

   // A new result always comes from an item that was in the window stage.
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(s1_valid_ff))
      else $error("result appeared without an item in the window stage");

   // Read and write of the same line entry in one cycle happen only for a
   // one-pixel-wide frame.
   a_forward_width: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_fwd_ff) |-> (w_eff == WID_W'(1)))
      else $error("line memory forwarding with a frame wider than one pixel");

endmodule

FILE: hw/rtl/sh3_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Reading an address in the cycle it is written returns the old data.
`timescale 1ns / 1ps

module sh3_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/sh3_sharpen.sv
// Combinational 3x3 sharpen kernel on all three color channels with saturation.
// Depends on sh3_pkg for the window and pixel types.
`timescale 1ns / 1ps

module sh3_sharpen (
   input  sh3_pkg::win_type win,
   output sh3_pkg::pix_type result
);
   import sh3_pkg::*;

   logic [NEG_W-1:0]         neg;
   logic [POS_W-1:0]         pos;
   logic signed [DIFF_W-1:0] diff;

   always_comb begin
      result = '0;
      neg    = '0;
      pos    = '0;
      diff   = '0;
      for (int ch = 0; ch < 3; ch++) begin
         // Center weighted by nine, the eight neighbors subtracted.
         neg = '0;
         for (int c = 0; c < 3; c++) begin
            for (int r = 0; r < 3; r++) begin
               if (!(c == 1 && r == 1)) begin
                  neg = neg + NEG_W'(win[c][r][ch*CH_W +: CH_W]);
               end
            end
         end
         pos  = POS_W'(win[1][1][ch*CH_W +: CH_W]) * POS_W'(KERNEL_CENTER);
         diff = $signed({1'b0, pos}) - $signed({2'b00, neg});
         if (diff < 0) begin
            result[ch*CH_W +: CH_W] = '0;
         end else if (diff > DIFF_W'(CH_MAX)) begin
            result[ch*CH_W +: CH_W] = CH_W'(CH_MAX);
         end else begin
            result[ch*CH_W +: CH_W] = diff[CH_W-1:0];
         end
      end
   end

endmodule

FILE: hw/rtl/sh3_ctrl.sv
// Input position tracking: column and row of the next item, flush handling and
// the per-item control decisions. Depends on sh3_pkg.
`timescale 1ns / 1ps

module sh3_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      restart,
   input  logic                      advance,
   input  logic                      flush,
   input  logic [sh3_pkg::WID_W-1:0] w_eff,
   input  logic [sh3_pkg::HGT_W-1:0] h_eff,
   output logic                      keep,
   output logic [sh3_pkg::COL_W-1:0] rd_addr,
   output sh3_pkg::ctl_type          ctl
);
   import sh3_pkg::*;

   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic             pixel_row;
   logic             frame_end;
   logic             last_col;

   assign pixel_row = row_ff < ROW_W'(h_eff);
   assign frame_end = row_ff > ROW_W'(h_eff);
   assign last_col  = (WID_W'(col_ff) + WID_W'(1)) == w_eff;

   // A flush item while pixels are still expected changes nothing.
   assign keep    = !(pixel_row && flush);
   assign rd_addr = col_ff;

   always_comb begin
      ctl.have      = (row_ff != '0) && (row_ff <= ROW_W'(h_eff));
      ctl.top_above = row_ff >= ROW_W'(2);
      ctl.bot_pixel = pixel_row;
      ctl.wr_line   = pixel_row;
      ctl.col0      = col_ff == '0;
      ctl.edge_emit = (col_ff == '0) && (row_ff >= ROW_W'(2));
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (restart) begin
         col_in = '0;
         row_in = '0;
      end else if (advance && keep) begin
         if (frame_end) begin
            col_in = '0;
            row_in = '0;
         end else if (last_col) begin
            col_in = '0;
            row_in = row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule
